### rtl/core/brb64_pkg.sv
// Package with the payload types, register codes and symbol encoder of the bit regrouper.
package brb64_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       msg_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       msg_end;
  } out_item_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_INPUT_FORMAT  = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_FORMAT = 2'd1;

  // Input format codes.
  localparam logic IN_FMT_HEX = 1'b0;
  localparam logic IN_FMT_RAW = 1'b1;

  // Output format codes; the unused code behaves as raw bytes.
  localparam logic [1:0] OUT_FMT_BASE64 = 2'd0;
  localparam logic [1:0] OUT_FMT_HEX    = 2'd1;
  localparam logic [1:0] OUT_FMT_RAW    = 2'd2;

  // ASCII characters used by the converters.
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_CASE    = 8'h20;

  // Base64 alphabet boundaries.
  localparam logic [7:0] B64_UPPER_END = 8'd26;
  localparam logic [7:0] B64_LOWER_END = 8'd52;
  localparam logic [7:0] B64_DIGIT_END = 8'd62;

  // Turns a symbol value into the character or byte of the given output format.
  function automatic logic [7:0] encode_symbol(input logic [7:0] v, input logic [1:0] fmt);
    logic [7:0] ch;
    ch = v;
    case (fmt)
      OUT_FMT_BASE64: begin
        if (v < B64_UPPER_END) begin
          ch = CH_UPPER_A + v;
        end else if (v < B64_LOWER_END) begin
          ch = CH_LOWER_A + (v - B64_UPPER_END);
        end else if (v < B64_DIGIT_END) begin
          ch = CH_ZERO + (v - B64_LOWER_END);
        end else if (v == B64_DIGIT_END) begin
          ch = CH_PLUS;
        end else begin
          ch = CH_SLASH;
        end
      end
      OUT_FMT_HEX: begin
        if (v < 8'd10) begin
          ch = CH_ZERO + v;
        end else begin
          ch = CH_LOWER_A + (v - 8'd10);
        end
      end
      default: ch = v;
    endcase
    return ch;
  endfunction

endpackage

### rtl/core/bit_regroup_base64_hex_encoder_unit.sv
// Top level of the streaming bit regrouper: hex digits or raw bytes in, base64, hex or bytes out.
//
//   Channel   Direction  Handshake               Payload
//   in_       in         in_valid / in_ready     brb64_pkg::in_item_t   (in_char, msg_last)
//   out_      out        out_valid / out_ready   brb64_pkg::out_item_t  (out_char, char_valid,
//                                                                         run_last, msg_end)
//   cfg_      in         cfg_valid / cfg_ready   cfg_index (2 bits), cfg_data (2 bits)
//
// An accepted input transaction waits in an input register; one combinational pass moves all
// of its symbols (at most three) into a three-entry result queue that drains one transaction
// per cycle while out_ready is high. The queue refills as its final entry leaves.
// Reset (rst_n low, synchronous) clears both formats, the bit buffer and both queues. Output
// stalls back up into the input register, which holds one more transaction; cfg never stalls.
module bit_regroup_base64_hex_encoder_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  brb64_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output brb64_pkg::out_item_t  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [1:0]            cfg_data
);

  // Configuration registers.
  logic       input_format_r;
  logic [1:0] output_format_r;

  // Stream state: pending bits sit in the low bit_count_r bits of bit_buffer_r.
  logic [15:0] bit_buffer_r, bit_buffer_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;

  // Input register.
  logic                 inq_valid_r;
  brb64_pkg::in_item_t  inq_data_r;

  // Result queue: entry 0 is presented on the output port.
  brb64_pkg::out_item_t res_q_r [3];
  brb64_pkg::out_item_t res_nxt [3];
  logic [1:0]           res_rem_r;
  logic [1:0]           res_cnt_nxt;

  logic pop;
  logic load;
  logic cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  assign out_valid = (res_rem_r != 2'd0);
  assign out_data  = res_q_r[0];
  assign pop       = out_valid && out_ready;

  // The held item moves into the result queue once the queue is empty or its final entry leaves.
  assign load     = inq_valid_r && ((res_rem_r == 2'd0) || ((res_rem_r == 2'd1) && out_ready));
  assign in_ready = !inq_valid_r || load;

  // Bit regrouping for the item in the input register.
  logic [3:0]  nbits;
  logic [7:0]  val;
  logic [7:0]  lc;
  logic [3:0]  sym_w;
  logic [7:0]  sym_mask;
  logic [15:0] buf_a;
  logic [3:0]  cnt_a;
  logic [3:0]  rest0, rest1, cnt_left;
  logic        emit0, emit1, emit_flush;
  logic [15:0] shift0, shift1, shift_f;
  brb64_pkg::out_item_t sym0, sym1, sym_f;

  always_comb begin
    nbits = 4'd0;
    val   = 8'd0;
    lc    = inq_data_r.in_char | brb64_pkg::CH_CASE;
    if (input_format_r == brb64_pkg::IN_FMT_RAW) begin
      nbits = 4'd8;
      val   = inq_data_r.in_char;
    end else if ((inq_data_r.in_char >= brb64_pkg::CH_ZERO) &&
                 (inq_data_r.in_char <= brb64_pkg::CH_NINE)) begin
      nbits = 4'd4;
      val   = inq_data_r.in_char - brb64_pkg::CH_ZERO;
    end else if (((inq_data_r.in_char >= brb64_pkg::CH_UPPER_A) &&
                  (inq_data_r.in_char <= brb64_pkg::CH_UPPER_Z)) ||
                 ((inq_data_r.in_char >= brb64_pkg::CH_LOWER_A) &&
                  (inq_data_r.in_char <= brb64_pkg::CH_LOWER_Z))) begin
      // Letters past f saturate to all ones.
      nbits = 4'd4;
      val   = (lc <= brb64_pkg::CH_LOWER_F) ? (lc - brb64_pkg::CH_LOWER_A + 8'd10) : 8'd15;
    end

    case (output_format_r)
      brb64_pkg::OUT_FMT_BASE64: sym_w = 4'd6;
      brb64_pkg::OUT_FMT_HEX:    sym_w = 4'd4;
      default:                   sym_w = 4'd8;
    endcase
    sym_mask = 8'((9'd1 << sym_w) - 9'd1);

    // At most seven bits are pending before the append, so the sum fits in four bits.
    buf_a = (bit_buffer_r << nbits) | {8'd0, val};
    cnt_a = bit_count_r + nbits;

    emit0 = (cnt_a >= sym_w);
    rest0 = emit0 ? (cnt_a - sym_w) : cnt_a;
    emit1 = emit0 && (rest0 >= sym_w);
    rest1 = emit1 ? (rest0 - sym_w) : rest0;
    cnt_left = rest1;
    emit_flush = inq_data_r.msg_last && (cnt_left != 4'd0);

    shift0 = buf_a >> rest0;
    shift1 = buf_a >> rest1;
    // Leftover bits move to the top of the symbol, zeros below them.
    shift_f = buf_a << (sym_w - cnt_left);

    sym0 = '0;
    sym0.out_char   = brb64_pkg::encode_symbol(shift0[7:0] & sym_mask, output_format_r);
    sym0.char_valid = 1'b1;
    sym1 = '0;
    sym1.out_char   = brb64_pkg::encode_symbol(shift1[7:0] & sym_mask, output_format_r);
    sym1.char_valid = 1'b1;
    sym_f = '0;
    sym_f.out_char   = brb64_pkg::encode_symbol(shift_f[7:0] & sym_mask, output_format_r);
    sym_f.char_valid = 1'b1;

    if (inq_data_r.msg_last) begin
      bit_buffer_nxt = 16'd0;
      bit_count_nxt  = 4'd0;
    end else begin
      bit_buffer_nxt = buf_a & ((16'd1 << cnt_left) - 16'd1);
      bit_count_nxt  = cnt_left;
    end
  end

  // Places the symbols of this item into queue order and marks the run and message ends.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_nxt[i] = '0;
    end
    res_cnt_nxt = 2'd0;
    if (emit0) begin
      res_nxt[0]  = sym0;
      res_cnt_nxt = 2'd1;
    end
    if (emit1) begin
      res_nxt[1]  = sym1;
      res_cnt_nxt = 2'd2;
    end
    if (emit_flush) begin
      res_nxt[res_cnt_nxt] = sym_f;
      res_cnt_nxt = res_cnt_nxt + 2'd1;
    end
    // A message that ends without a symbol still gets an empty end marker.
    if (inq_data_r.msg_last && (res_cnt_nxt == 2'd0)) begin
      res_cnt_nxt = 2'd1;
    end
    if (res_cnt_nxt != 2'd0) begin
      res_nxt[res_cnt_nxt - 2'd1].run_last = 1'b1;
      res_nxt[res_cnt_nxt - 2'd1].msg_end  = inq_data_r.msg_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_format_r  <= brb64_pkg::IN_FMT_HEX;
      output_format_r <= brb64_pkg::OUT_FMT_BASE64;
      bit_buffer_r    <= 16'd0;
      bit_count_r     <= 4'd0;
      inq_valid_r     <= 1'b0;
      res_rem_r       <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        inq_valid_r <= 1'b1;
      end else if (load) begin
        inq_valid_r <= 1'b0;
      end

      if (load) begin
        res_rem_r    <= res_cnt_nxt;
        bit_buffer_r <= bit_buffer_nxt;
        bit_count_r  <= bit_count_nxt;
      end else if (pop) begin
        res_rem_r <= res_rem_r - 2'd1;
      end

      // Any write to a defined register restarts the stream with an empty buffer.
      if (cfg_write) begin
        unique case (cfg_index)
          brb64_pkg::CFG_INPUT_FORMAT: begin
            input_format_r <= cfg_data[0];
            bit_buffer_r   <= 16'd0;
            bit_count_r    <= 4'd0;
          end
          brb64_pkg::CFG_OUTPUT_FORMAT: begin
            output_format_r <= cfg_data;
            bit_buffer_r    <= 16'd0;
            bit_count_r     <= 4'd0;
          end
          default: ;
        endcase
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_data_r <= in_data;
    end
    if (load) begin
      res_q_r[0] <= res_nxt[0];
      res_q_r[1] <= res_nxt[1];
      res_q_r[2] <= res_nxt[2];
    end else if (pop) begin
      res_q_r[0] <= res_q_r[1];
      res_q_r[1] <= res_q_r[2];
    end
  end

endmodule

### rtl/core/brb64_checker.sv
// Port-level checker for the bit regrouper, with its bind to the top level.
module brb64_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input brb64_pkg::out_item_t out_data
);

  // A stalled output transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // The end of a message is always the end of a run.
  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.msg_end |-> out_data.run_last)
    else $error("msg_end without run_last");

  // An empty result only appears as the end marker of a message, with a zero character.
  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.char_valid |->
      out_data.run_last && out_data.msg_end && (out_data.out_char == 8'd0))
    else $error("malformed empty end marker");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind bit_regroup_base64_hex_encoder_unit brb64_checker u_brb64_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
